// File: sv/gtc_pkg.sv
// gtc_pkg: constants, types and helper functions for the grid three-colouring counter
// used by the item interfaces, the controller, the datapath and the top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gtc_pkg;

    // grid and pattern sizing
    localparam int MAX_ROWS  = 5;
    localparam int PAT_DEPTH = 3 << (MAX_ROWS - 1);
    localparam int PAT_W     = 2 * MAX_ROWS;
    localparam int IDX_W     = $clog2(PAT_DEPTH);
    localparam int TOT_W     = $clog2(PAT_DEPTH + 1);
    localparam int RSAT_W    = $clog2(MAX_ROWS + 1);

    // item field widths
    localparam int ROWS_W = 3;
    localparam int COLS_W = 16;
    localparam int VAL_W  = 30;

    localparam logic [VAL_W-1:0] MODULUS   = 30'd1000000007;
    localparam logic [1:0]       COLOR_MAX = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // latch a new query
        logic enum_step;   // one step of the pattern walk
        logic issue;       // read one previous-column entry
        logic sum_mode;    // accumulate without the compatibility check
        logic write_next;  // store the finished row sum
        logic out_load;    // move the total into the output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic enum_done;
        logic issue_last;
        logic cur_last;
        logic col_last;
        logic cols_le1;
        logic out_free;
    } t_dp_sts;

    // modular add with one conditional subtraction
    function automatic logic [VAL_W-1:0] add_mod(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS}) begin
            s = s - {1'b0, MODULUS};
        end
        return s[VAL_W-1:0];
    endfunction

    // true when two column patterns differ in every used cell
    function automatic logic patterns_disjoint(input logic [PAT_W-1:0]  a,
                                               input logic [PAT_W-1:0]  b,
                                               input logic [RSAT_W-1:0] rows);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < MAX_ROWS; i++) begin
            if (i < int'(rows) && a[2*i +: 2] == b[2*i +: 2]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // true when no two vertical neighbours share a colour
    function automatic logic pattern_proper(input logic [PAT_W-1:0]  p,
                                            input logic [RSAT_W-1:0] rows);
        logic ok;
        ok = 1'b1;
        for (int i = 1; i < MAX_ROWS; i++) begin
            if (i < int'(rows) && p[2*i +: 2] == p[2*(i-1) +: 2]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// File: sv/gtc_query_if.sv
// gtc_query_if: valid/ready channel carrying one query item (grid height and width)
// depends on gtc_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface gtc_query_if;
    logic                          valid;
    logic                          ready;
    logic [gtc_pkg::ROWS_W-1:0]    row_count;
    logic [gtc_pkg::COLS_W-1:0]    column_count;

    modport source (output valid, output row_count, output column_count, input ready);
    modport sink   (input valid, input row_count, input column_count, output ready);
endinterface

`default_nettype wire

// File: sv/gtc_result_if.sv
// gtc_result_if: valid/ready channel carrying one result item (colouring count)
// depends on gtc_pkg for the field width
`timescale 1ns / 1ps
`default_nettype none

interface gtc_result_if;
    logic                         valid;
    logic                         ready;
    logic [gtc_pkg::VAL_W-1:0]    coloring_count;

    modport source (output valid, output coloring_count, input ready);
    modport sink   (input valid, input coloring_count, output ready);
endinterface

`default_nettype wire

// File: sv/gtc_ctrl.sv
// gtc_ctrl: sequencing state machine for the colouring counter
// issues commands to gtc_datapath, depends on gtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gtc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  gtc_pkg::t_dp_sts    i_sts,
    output gtc_pkg::t_dp_cmd    o_cmd
);
    import gtc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENUM,
        S_ROW,
        S_ROW_DRAIN,
        S_ROW_WRITE,
        S_SUM,
        S_SUM_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ENUM;
                end
            end
            S_ENUM: begin
                o_cmd.enum_step = 1'b1;
                if (i_sts.enum_done) begin
                    n_state = i_sts.cols_le1 ? S_SUM : S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.issue = 1'b1;
                if (i_sts.issue_last) begin
                    n_state = S_ROW_DRAIN;
                end
            end
            S_ROW_DRAIN: begin
                n_state = S_ROW_WRITE;
            end
            S_ROW_WRITE: begin
                o_cmd.write_next = 1'b1;
                n_state = (i_sts.cur_last && i_sts.col_last) ? S_SUM : S_ROW;
            end
            S_SUM: begin
                o_cmd.issue    = 1'b1;
                o_cmd.sum_mode = 1'b1;
                if (i_sts.issue_last) begin
                    n_state = S_SUM_DRAIN;
                end
            end
            S_SUM_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: sv/gtc_datapath.sv
// gtc_datapath: pattern walk, pattern and count memories, modular accumulator, output register
// driven by gtc_ctrl commands, depends on gtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gtc_datapath (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  gtc_pkg::t_dp_cmd            i_cmd,
    output gtc_pkg::t_dp_sts            o_sts,
    input  wire [gtc_pkg::ROWS_W-1:0]   i_row_count,
    input  wire [gtc_pkg::COLS_W-1:0]   i_column_count,
    input  wire                         i_out_ready,
    output logic                        o_out_valid,
    output logic [gtc_pkg::VAL_W-1:0]   o_out_data
);
    import gtc_pkg::*;

    // query registers
    logic [RSAT_W-1:0] r_rows;
    logic [COLS_W-1:0] r_cols;
    logic [COLS_W-1:0] r_col;

    // walk and index registers
    logic [PAT_W-1:0]  r_digits;
    logic [TOT_W-1:0]  r_total;
    logic [IDX_W-1:0]  r_cur;
    logic [IDX_W-1:0]  r_prev;
    logic              r_bank;

    // memories
    logic [PAT_W-1:0]  r_pat_mem  [PAT_DEPTH];
    logic [VAL_W-1:0]  r_cnt_mem0 [PAT_DEPTH];
    logic [VAL_W-1:0]  r_cnt_mem1 [PAT_DEPTH];

    // registered read data
    logic [PAT_W-1:0]  r_pat_a;
    logic [PAT_W-1:0]  r_pat_b;
    logic [VAL_W-1:0]  r_rd0;
    logic [VAL_W-1:0]  r_rd1;
    logic              r_rd_valid;
    logic              r_rd_sum;

    logic [VAL_W-1:0]  r_acc;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_data;

    logic [PAT_W-1:0]  n_digits;
    logic              carry;
    logic              pat_write;
    logic [TOT_W-1:0]  last_idx;
    logic              cnt_we;
    logic              cnt_wbank;
    logic [IDX_W-1:0]  cnt_waddr;
    logic [VAL_W-1:0]  cnt_wdata;
    logic [VAL_W-1:0]  rd_cnt;
    logic [ROWS_W:0]   rows_ext;

    // next pattern of the base-3 walk, last cell least significant
    always_comb begin
        n_digits = r_digits;
        carry    = 1'b1;
        for (int i = MAX_ROWS - 1; i >= 0; i--) begin
            if (i < int'(r_rows) && carry) begin
                if (r_digits[2*i +: 2] == COLOR_MAX) begin
                    n_digits[2*i +: 2] = 2'd0;
                end else begin
                    n_digits[2*i +: 2] = r_digits[2*i +: 2] + 2'd1;
                    carry              = 1'b0;
                end
            end
        end
    end

    assign pat_write = i_cmd.enum_step && pattern_proper(r_digits, r_rows)
                       && (r_total != TOT_W'(PAT_DEPTH));
    assign last_idx  = r_total - TOT_W'(1);
    assign rows_ext  = {1'b0, i_row_count};

    // count memory write port: initial ones during the walk, row sums later
    always_comb begin
        cnt_we    = 1'b0;
        cnt_wbank = r_bank;
        cnt_waddr = r_total[IDX_W-1:0];
        cnt_wdata = VAL_W'(1);
        if (pat_write) begin
            cnt_we = 1'b1;
        end else if (i_cmd.write_next) begin
            cnt_we    = 1'b1;
            cnt_wbank = ~r_bank;
            cnt_waddr = r_cur;
            cnt_wdata = r_acc;
        end
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (pat_write) begin
            r_pat_mem[r_total[IDX_W-1:0]] <= r_digits;
        end
        if (cnt_we && !cnt_wbank) begin
            r_cnt_mem0[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_we && cnt_wbank) begin
            r_cnt_mem1[cnt_waddr] <= cnt_wdata;
        end
    end

    // memory reads, registered
    always_ff @(posedge i_clk) begin
        r_pat_a <= r_pat_mem[r_cur];
        r_pat_b <= r_pat_mem[r_prev];
        r_rd0   <= r_cnt_mem0[r_prev];
        r_rd1   <= r_cnt_mem1[r_prev];
    end

    assign rd_cnt = r_bank ? r_rd1 : r_rd0;

    // query latch and walk state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rows   <= (rows_ext > (ROWS_W+1)'(MAX_ROWS)) ? RSAT_W'(MAX_ROWS)
                                                           : RSAT_W'(i_row_count);
            r_cols   <= i_column_count;
            r_digits <= '0;
        end else if (i_cmd.enum_step) begin
            r_digits <= n_digits;
        end
    end

    // indices, column counter and bank select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_cur   <= '0;
            r_prev  <= '0;
            r_col   <= '0;
            r_bank  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_total <= '0;
                r_cur   <= '0;
                r_prev  <= '0;
                r_col   <= COLS_W'(1);
            end else begin
                if (pat_write) begin
                    r_total <= r_total + TOT_W'(1);
                end
                if (i_cmd.issue) begin
                    r_prev <= o_sts.issue_last ? '0 : r_prev + IDX_W'(1);
                end
                if (i_cmd.write_next) begin
                    if (o_sts.cur_last) begin
                        r_cur  <= '0;
                        r_col  <= r_col + COLS_W'(1);
                        r_bank <= ~r_bank;
                    end else begin
                        r_cur <= r_cur + IDX_W'(1);
                    end
                end
            end
        end
    end

    // read pipeline flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_rd_sum   <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.issue;
            r_rd_sum   <= i_cmd.sum_mode;
        end
    end

    // modular accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.load || i_cmd.write_next) begin
            r_acc <= '0;
        end else if (r_rd_valid
                     && (r_rd_sum || patterns_disjoint(r_pat_a, r_pat_b, r_rows))) begin
            r_acc <= add_mod(r_acc, rd_cnt);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_acc;
        end
    end

    // status
    always_comb begin
        o_sts.enum_done  = carry;
        o_sts.issue_last = (TOT_W'(r_prev) == last_idx);
        o_sts.cur_last   = (TOT_W'(r_cur) == last_idx);
        o_sts.col_last   = ((r_col + COLS_W'(1)) == r_cols);
        o_sts.cols_le1   = (r_cols <= COLS_W'(1));
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: sv/grid_three_coloring_counter.sv
// grid_three_coloring_counter: proper three-colourings of a grid, modulo 1000000007
// with N = 3*2^(rows-1) patterns (one for zero height): a base-3 walk keeps proper columns,
// a pass over all N*N pattern pairs per further column, a summing pass, the output load
// one query at a time; the N*N pair loop on one shared accumulator sets the rate
// the result register lets the next query start while a result waits to be taken
// synchronous active-low reset returns to idle; memories are not cleared
`timescale 1ns / 1ps
`default_nettype none

module grid_three_coloring_counter (
    input  wire             i_clk,
    input  wire             i_rst_n,
    gtc_query_if.sink       i_query,
    gtc_result_if.source    o_result
);
    import gtc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    // sequencing
    gtc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_query.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // walk, memories and accumulation
    gtc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_row_count    (i_query.row_count),
        .i_column_count (i_query.column_count),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_out_data     (o_result.coloring_count)
    );

    assign i_query.ready = in_ready;

    // a delivered count is always reduced
    a_result_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.coloring_count < MODULUS))
        else $error("result not reduced modulo the prime");

    // a total is never moved over a result still waiting
    a_out_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_result.valid || o_result.ready))
        else $error("output register overwritten");

    // an accepted item starts the pattern walk in the following cycle
    a_accept_walks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_query.valid && i_query.ready) |=> cmd.enum_step)
        else $error("pattern walk did not start");

    // the output is loaded only after the summing pass has drained
    a_load_after_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load && !$past(cmd.out_load)) |-> !$past(cmd.issue))
        else $error("output loaded during a pass");

endmodule

`default_nettype wire

// File: bench/grid_three_coloring_counter_tb.sv
// grid_three_coloring_counter_tb: checks colouring counts against a transfer-matrix predictor
// depends on gtc_pkg, gtc_query_if, gtc_result_if and grid_three_coloring_counter
`timescale 1ns / 1ps

module grid_three_coloring_counter_tb;

    localparam int unsigned GRID_PRIME    = 1000000007;
    localparam int          PATTERN_SLOTS = gtc_pkg::PAT_DEPTH;

    typedef struct {
        bit [gtc_pkg::ROWS_W-1:0] rows;
        bit [gtc_pkg::COLS_W-1:0] cols;
        bit [gtc_pkg::VAL_W-1:0]  count;
    } t_grid_answer;

    logic i_clk;
    logic i_rst_n;

    gtc_query_if  query_ch ();
    gtc_result_if result_ch ();

    t_grid_answer awaited_counts [$];
    int           mismatch_count = 0;
    longint       cycle_count    = 0;
    longint       cycle_limit    = 5000;
    int           hold_left      = 0;
    bit           tx_idling      = 1'b1;
    bit           rx_idling      = 1'b1;

    grid_three_coloring_counter uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_query  (query_ch),
        .o_result (result_ch)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // proper three-colourings of a rows x cols grid, plus a rough cycle cost
    function automatic bit [gtc_pkg::VAL_W-1:0] count_grid_colourings(
            input  bit [gtc_pkg::ROWS_W-1:0] rows_in,
            input  bit [gtc_pkg::COLS_W-1:0] cols_in,
            output longint                   cost);
        int unsigned height;
        int unsigned combos;
        int unsigned n;
        int unsigned code;
        int unsigned acc;
        bit [gtc_pkg::PAT_W-1:0] pat;
        bit [gtc_pkg::PAT_W-1:0] col_pat [PATTERN_SLOTS];
        bit [gtc_pkg::VAL_W-1:0] ways [PATTERN_SLOTS];
        bit [gtc_pkg::VAL_W-1:0] ways_next [PATTERN_SLOTS];
        bit                      fits [PATTERN_SLOTS][PATTERN_SLOTS];
        bit                      proper;
        height = (rows_in > gtc_pkg::MAX_ROWS) ? gtc_pkg::MAX_ROWS : rows_in;
        combos = 1;
        for (int i = 0; i < height; i++) combos = combos * 3;
        // keep every base-3 column whose vertical neighbours differ
        n = 0;
        for (int v = 0; v < combos; v++) begin
            code   = v;
            proper = 1'b1;
            pat    = '0;
            for (int i = 0; i < height; i++) begin
                pat[2*i +: 2] = 2'(code % 3);
                code = code / 3;
                if (i > 0 && pat[2*i +: 2] == pat[2*i-2 +: 2]) proper = 1'b0;
            end
            if (proper) begin
                col_pat[n] = pat;
                n++;
            end
        end
        // neighbouring columns must differ in every cell
        for (int a = 0; a < n; a++) begin
            for (int b = 0; b < n; b++) begin
                fits[a][b] = 1'b1;
                for (int i = 0; i < height; i++) begin
                    if (col_pat[a][2*i +: 2] == col_pat[b][2*i +: 2]) fits[a][b] = 1'b0;
                end
            end
        end
        for (int a = 0; a < n; a++) ways[a] = gtc_pkg::VAL_W'(1);
        for (int c = 1; c < cols_in; c++) begin
            for (int a = 0; a < n; a++) begin
                acc = 0;
                for (int b = 0; b < n; b++) begin
                    if (fits[a][b]) begin
                        acc = acc + ways[b];
                        if (acc >= GRID_PRIME) acc = acc - GRID_PRIME;
                    end
                end
                ways_next[a] = acc[gtc_pkg::VAL_W-1:0];
            end
            ways = ways_next;
        end
        acc = 0;
        for (int a = 0; a < n; a++) begin
            acc = acc + ways[a];
            if (acc >= GRID_PRIME) acc = acc - GRID_PRIME;
        end
        cost = combos + n + 3;
        if (cols_in > 1) cost = cost + longint'(cols_in - 1) * n * (n + 2);
        return acc[gtc_pkg::VAL_W-1:0];
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // offer one query, wait for its handshake, then record the answer
    task automatic send_query(input bit [gtc_pkg::ROWS_W-1:0] rows,
                              input bit [gtc_pkg::COLS_W-1:0] cols);
        int           gap;
        longint       cost;
        t_grid_answer ans;
        gap = (tx_idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            query_ch.valid        = 1'b0;
            query_ch.row_count    = gtc_pkg::ROWS_W'($urandom);
            query_ch.column_count = gtc_pkg::COLS_W'($urandom);
        end
        @(negedge i_clk);
        query_ch.valid        = 1'b1;
        query_ch.row_count    = rows;
        query_ch.column_count = cols;
        @(posedge i_clk);
        while (!query_ch.ready) @(posedge i_clk);
        ans.rows  = rows;
        ans.cols  = cols;
        ans.count = count_grid_colourings(rows, cols, cost);
        awaited_counts = {awaited_counts, ans};
        cycle_limit = cycle_limit + 4 * cost + 64;
    endtask

    // stop offering and let every outstanding answer come back
    task automatic wait_for_results();
        @(negedge i_clk);
        query_ch.valid = 1'b0;
        while (awaited_counts.size() != 0) @(posedge i_clk);
    endtask

    // random heights, widths kept short enough for the larger heights
    task automatic run_random_queries(input int count);
        bit [gtc_pkg::ROWS_W-1:0] rows;
        bit [gtc_pkg::COLS_W-1:0] cols;
        int unsigned              height;
        int unsigned              n;
        int unsigned              cap;
        repeat (count) begin
            rows   = gtc_pkg::ROWS_W'($urandom_range(0, 7));
            height = (rows > gtc_pkg::MAX_ROWS) ? gtc_pkg::MAX_ROWS : rows;
            n      = (height == 0) ? 1 : (3 << (height - 1));
            cap    = 8000 / (n * (n + 2)) + 2;
            if ($urandom_range(0, 9) == 0) cols = gtc_pkg::COLS_W'($urandom_range(0, 1));
            else cols = gtc_pkg::COLS_W'($urandom_range(2, cap));
            send_query(rows, cols);
        end
    endtask

    // field extremes, zero height, zero width and saturated height
    task automatic test_directed_extremes();
        for (int r = 0; r < 8; r++) send_query(gtc_pkg::ROWS_W'(r), 1);
        send_query(0, 0);
        send_query(3, 0);
        send_query(5, 0);
        send_query(0, 16'hFFFF);
        send_query(1, 2);
        send_query(2, 3);
        send_query(5, 2);
        send_query(7, 3);
        send_query(6, 4);
        send_query(5, 20);
        send_query(4, 30);
        send_query(3, 100);
        send_query(2, 600);
        send_query(1, 2000);
    endtask

    // receiver holds off while short queries keep coming, so the input stalls
    task automatic test_output_hold();
        wait_for_results();
        tx_idling   = 1'b0;
        hold_left   = 400;
        cycle_limit = cycle_limit + 800;
        repeat (8) send_query(gtc_pkg::ROWS_W'($urandom_range(0, 1)),
                              gtc_pkg::COLS_W'($urandom_range(1, 3)));
        tx_idling = 1'b1;
    endtask

    task automatic test_random_queries();
        wait_for_results();
        run_random_queries(50);
    endtask

    // closing stretch with both sides always ready
    task automatic test_steady_stream();
        wait_for_results();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        run_random_queries(20);
    endtask

    // result side ready: long hold first, then random stall bursts
    initial begin : result_sink
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                result_ch.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                result_ch.ready = 1'b0;
                stall_left--;
            end else if (rx_idling && $urandom_range(0, 7) == 0) begin
                result_ch.ready = 1'b0;
                stall_left      = $urandom_range(1, 6) - 1;
            end else begin
                result_ch.ready = 1'b1;
            end
        end
    end

    // compare each taken result with the oldest awaited answer
    always @(posedge i_clk) begin : result_check
        t_grid_answer head;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (awaited_counts.size() == 0) begin
                report_mismatch($sformatf("result %0d with no query outstanding",
                                          result_ch.coloring_count));
            end else begin
                head = awaited_counts.pop_front();
                if (result_ch.coloring_count !== head.count) begin
                    report_mismatch($sformatf("rows %0d cols %0d: got %0d, want %0d",
                                              head.rows, head.cols,
                                              result_ch.coloring_count, head.count));
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count <= cycle_limit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        query_ch.valid        = 1'b0;
        query_ch.row_count    = '0;
        query_ch.column_count = '0;
        i_rst_n               = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_extremes();
        test_output_hold();
        test_random_queries();
        test_steady_stream();

        wait_for_results();
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
